/* src/rhcc_pkg.sv */
// ----------------------------------------------------------------------------
// rhcc_pkg: shared types and helpers for the RGB to HSV colour classifier
// Word layouts, pipeline stage records, colour codes, thresholds, divider step
// and the classification table.
// ----------------------------------------------------------------------------
package rhcc_pkg;

    // APB register map
    localparam int unsigned ADDR_W = 3;
    localparam logic REG_BRIGHTNESS = 1'b0;   // register index, paddr[2]

    // Divider: 13 quotient bits, two per stage (one in the last stage)
    localparam int unsigned DIV_STEPS      = 13;
    localparam int unsigned STEPS_PER_STG  = 2;
    localparam int unsigned DIV_STAGES     = (DIV_STEPS + STEPS_PER_STG - 1) / STEPS_PER_STG;

    // Colour codes
    localparam logic [3:0] CLR_WHITE   = 4'd0;
    localparam logic [3:0] CLR_GRAY    = 4'd1;
    localparam logic [3:0] CLR_BLACK   = 4'd2;
    localparam logic [3:0] CLR_RED     = 4'd3;
    localparam logic [3:0] CLR_BROWN   = 4'd4;
    localparam logic [3:0] CLR_ORANGE  = 4'd5;
    localparam logic [3:0] CLR_YELLOW  = 4'd6;
    localparam logic [3:0] CLR_GREEN   = 4'd7;
    localparam logic [3:0] CLR_BLUE    = 4'd8;
    localparam logic [3:0] CLR_PINK    = 4'd9;
    localparam logic [3:0] CLR_PURPLE  = 4'd10;
    localparam logic [3:0] CLR_UNKNOWN = 4'd11;

    // Hue in 1/64 degree
    localparam logic [14:0] HUE_30  = 15'd1920;
    localparam logic [14:0] HUE_40  = 15'd2560;
    localparam logic [14:0] HUE_65  = 15'd4160;
    localparam logic [14:0] HUE_120 = 15'd7680;
    localparam logic [14:0] HUE_165 = 15'd10560;
    localparam logic [14:0] HUE_240 = 15'd15360;
    localparam logic [14:0] HUE_265 = 15'd16960;
    localparam logic [14:0] HUE_300 = 15'd19200;
    localparam logic [14:0] HUE_340 = 15'd21760;
    localparam logic [14:0] HUE_360 = 15'd23040;

    // Percent in 1/64
    localparam logic [13:0] PCT_5   = 14'd320;
    localparam logic [13:0] PCT_10  = 14'd640;
    localparam logic [13:0] PCT_15  = 14'd960;
    localparam logic [13:0] PCT_50  = 14'd3200;
    localparam logic [13:0] PCT_80  = 14'd5120;
    localparam logic [13:0] PCT_85  = 14'd5440;

    // Scale factors
    localparam logic [21:0] SAT_SCALE = 22'd6400;   // d*6400/max
    localparam logic [21:0] HUE_SCALE = 22'd3840;   // 60 deg * 64 per unit of d
    localparam logic [13:0] VAL_SCALE = 14'd25;     // max*100*64/256

    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  color_code;
        logic [14:0] hue_angle;
        logic [12:0] saturation_pct;
        logic [13:0] value_pct;
    } out_word_t;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // Offset channels
    typedef struct packed {
        logic [8:0] red;
        logic [8:0] green;
        logic [8:0] blue;
    } chan_t;

    // Max/min and hue difference
    typedef struct packed {
        logic [8:0] mx;
        logic [8:0] d;
        logic [8:0] mag;
        logic       neg;
        sector_t    sector;
    } span_t;

    // One restoring-divider lane
    typedef struct packed {
        logic [12:0] num;      // numerator bits still to feed, MSB first
        logic [8:0]  rem;
        logic [12:0] quot;
        logic [8:0]  divisor;
    } div_lane_t;

    typedef struct packed {
        div_lane_t   sat;
        div_lane_t   hue;
        logic [13:0] value;
        logic        neg;
        logic        neutral;
        sector_t     sector;
    } div_stage_t;

    typedef struct packed {
        logic [14:0] hue;
        logic [12:0] sat;
        logic [13:0] value;
    } hsv_t;

    function automatic div_lane_t div_step(input div_lane_t l);
        logic [9:0] trial;
        logic [9:0] diff;
        div_lane_t  o;
        o     = l;
        trial = {l.rem, l.num[12]};
        diff  = trial - {1'b0, l.divisor};
        if (trial >= {1'b0, l.divisor})
        begin
            o.rem  = diff[8:0];
            o.quot = {l.quot[11:0], 1'b1};
        end
        else
        begin
            o.rem  = trial[8:0];
            o.quot = {l.quot[11:0], 1'b0};
        end
        o.num = {l.num[11:0], 1'b0};
        return o;
    endfunction

    function automatic logic [3:0] classify(input logic [14:0] h, input logic [12:0] s,
                                            input logic [13:0] v);
        logic        sat_low;
        logic [13:0] sw;
        logic [3:0]  c;
        sw      = {1'b0, s};
        sat_low = sw <= PCT_10;
        if (h > HUE_360)
            c = CLR_UNKNOWN;
        else if (sat_low && v > PCT_85)
            c = CLR_WHITE;
        else if (sat_low && v > PCT_15)
            c = CLR_GRAY;
        else if (v <= PCT_15)
            c = CLR_BLACK;
        else if (h < HUE_30 || h >= HUE_340)
            c = CLR_RED;
        else if (h < HUE_40)
            c = (sw >= PCT_50 && v <= PCT_80) ? CLR_BROWN : CLR_ORANGE;
        else if (h < HUE_65)
            c = CLR_YELLOW;
        else if (h < HUE_165)
            c = CLR_GREEN;
        else if (h < HUE_265)
            c = CLR_BLUE;
        else if (h >= HUE_300 && sw > PCT_5 && v >= PCT_80)
            c = CLR_PINK;
        else
            c = CLR_PURPLE;
        return c;
    endfunction

endpackage

/* src/rgb_hsv_color_classifier.sv */
// ----------------------------------------------------------------------------
// rgb_hsv_color_classifier: pixel colour naming via HSV
// Adds a brightness offset, converts RGB to HSV in 1/64 fixed point and names
// the colour from hue band and saturation/value thresholds.
// ----------------------------------------------------------------------------
// Pipeline: 12 register stages, the first loaded at acceptance.
// Throughput: one word per cycle when the output is not stalled; the 7-stage pipelined divider
//   (two quotient bits per stage, one in the last) then takes a new pair each cycle.
// Reset: rst_n clears all stage valid bits and the brightness offset (offset_reg) to 0.
//   Datapath registers are not reset.
// ----------------------------------------------------------------------------
module rgb_hsv_color_classifier
(
    input  logic                          clk,
    input  logic                          rst_n,
    // pixel word in
    input  logic                          pix_valid,
    output logic                          pix_ready,
    input  rhcc_pkg::in_word_t            pix,
    // result word out
    output logic                          res_valid,
    input  logic                          res_ready,
    output rhcc_pkg::out_word_t           res,
    // APB register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rhcc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rhcc_pkg::*;

    // Stage map: 0 offset add, 1 max/min/diff, 2 numerators,
    // 3..3+DIV_STAGES-1 divider, then hue assembly, then classify/output.
    localparam int unsigned STG_DIV0 = 3;
    localparam int unsigned STG_HSV  = STG_DIV0 + DIV_STAGES;
    localparam int unsigned STG_OUT  = STG_HSV + 1;
    localparam int unsigned NSTG     = STG_OUT + 1;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [7:0] offset_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BRIGHTNESS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= 8'd0;
        else if (cfg_wr)
            offset_reg <= pwdata[7:0];
    end

    always_comb
    begin
        if (paddr[2] == REG_BRIGHTNESS)
            prdata = {24'd0, offset_reg};
        else
            prdata = 32'd0;
    end

    // ------------------------------------------------------------------
    // Flow control: a stage loads when empty or when the one after moves,
    // so bubbles are squeezed out and a stall holds the full run at the end.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || res_ready;
        for (int i = NSTG - 2; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
        vld_next[0] = pix_valid;
        for (int i = 1; i < NSTG; i++)
            vld_next[i] = vld_reg[i-1];
    end

    assign pix_ready = en[0];
    assign res_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            for (int i = 0; i < NSTG; i++)
                if (en[i])
                    vld_reg[i] <= vld_next[i];
    end

    // ------------------------------------------------------------------
    // Stage 0: brightness offset, channels widen to 9 bits
    // ------------------------------------------------------------------
    chan_t ch_reg, ch_next;

    always_comb
    begin
        ch_next.red   = {1'b0, pix.red_level}   + {1'b0, offset_reg};
        ch_next.green = {1'b0, pix.green_level} + {1'b0, offset_reg};
        ch_next.blue  = {1'b0, pix.blue_level}  + {1'b0, offset_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            ch_reg <= ch_next;
    end

    // ------------------------------------------------------------------
    // Stage 1: max, min, chroma, sector and signed hue difference.
    // Ties for max go red first, then green.
    // ------------------------------------------------------------------
    span_t      sp_reg, sp_next;
    logic [8:0] mx, mn;
    logic       gb_neg, br_neg, rg_neg;
    logic [8:0] gb_mag, br_mag, rg_mag;

    always_comb
    begin
        mx = ch_reg.red;
        if (ch_reg.green > mx)
            mx = ch_reg.green;
        if (ch_reg.blue > mx)
            mx = ch_reg.blue;
        mn = ch_reg.red;
        if (ch_reg.green < mn)
            mn = ch_reg.green;
        if (ch_reg.blue < mn)
            mn = ch_reg.blue;

        // the three candidate differences, worked in parallel
        gb_neg = ch_reg.green < ch_reg.blue;
        gb_mag = gb_neg ? ch_reg.blue - ch_reg.green : ch_reg.green - ch_reg.blue;
        br_neg = ch_reg.blue < ch_reg.red;
        br_mag = br_neg ? ch_reg.red - ch_reg.blue : ch_reg.blue - ch_reg.red;
        rg_neg = ch_reg.red < ch_reg.green;
        rg_mag = rg_neg ? ch_reg.green - ch_reg.red : ch_reg.red - ch_reg.green;

        sp_next.mx = mx;
        sp_next.d  = mx - mn;
        if (mx == ch_reg.red)
        begin
            sp_next.sector = SEC_RED;
            sp_next.neg    = gb_neg;
            sp_next.mag    = gb_mag;
        end
        else if (mx == ch_reg.green)
        begin
            sp_next.sector = SEC_GREEN;
            sp_next.neg    = br_neg;
            sp_next.mag    = br_mag;
        end
        else
        begin
            sp_next.sector = SEC_BLUE;
            sp_next.neg    = rg_neg;
            sp_next.mag    = rg_mag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            sp_reg <= sp_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: scaled numerators (constant multiplies) and value.
    // Both quotients fit 13 bits, so the top numerator bits seed the
    // remainder directly.
    // ------------------------------------------------------------------
    div_stage_t nm_reg, nm_next;
    logic [21:0] sat_num, hue_num;

    always_comb
    begin
        sat_num = {13'd0, sp_reg.d}   * SAT_SCALE;
        hue_num = {13'd0, sp_reg.mag} * HUE_SCALE;

        nm_next.sat.rem     = sat_num[21:13];
        nm_next.sat.num     = sat_num[12:0];
        nm_next.sat.quot    = '0;
        nm_next.sat.divisor = sp_reg.mx;

        nm_next.hue.rem     = hue_num[21:13];
        nm_next.hue.num     = hue_num[12:0];
        nm_next.hue.quot    = '0;
        nm_next.hue.divisor = sp_reg.d;

        nm_next.value   = {5'd0, sp_reg.mx} * VAL_SCALE;
        nm_next.neg     = sp_reg.neg;
        nm_next.neutral = (sp_reg.d == 9'd0);
        nm_next.sector  = sp_reg.sector;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
            nm_reg <= nm_next;
    end

    // ------------------------------------------------------------------
    // Divider pipeline: two restoring steps per stage on both lanes, one in the last stage
    // ------------------------------------------------------------------
    div_stage_t div_reg  [DIV_STAGES];
    div_stage_t div_next [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        always_comb
        begin
            if (j == 0)
                div_next[j] = nm_reg;
            else
                div_next[j] = div_reg[(j == 0) ? 0 : j - 1];
            for (int k = 0; k < STEPS_PER_STG; k++)
                if (j * STEPS_PER_STG + k < DIV_STEPS)
                begin
                    div_next[j].sat = div_step(div_next[j].sat);
                    div_next[j].hue = div_step(div_next[j].hue);
                end
        end

        always_ff @(posedge clk)
        begin
            if (en[STG_DIV0 + j])
                div_reg[j] <= div_next[j];
        end
    end

    // ------------------------------------------------------------------
    // Hue assembly from sector base and quotient; neutral pixels give 0/0
    // ------------------------------------------------------------------
    hsv_t        hsv_reg, hsv_next;
    div_stage_t  dv;
    logic [14:0] q;

    always_comb
    begin
        dv = div_reg[DIV_STAGES-1];
        q  = {3'd0, dv.hue.quot[11:0]};
        case (dv.sector)
            SEC_RED:   hsv_next.hue = dv.neg ? HUE_360 - q : q;
            SEC_GREEN: hsv_next.hue = dv.neg ? HUE_120 - q : HUE_120 + q;
            SEC_BLUE:  hsv_next.hue = dv.neg ? HUE_240 - q : HUE_240 + q;
            default:   hsv_next.hue = '0;
        endcase
        hsv_next.sat   = dv.sat.quot;
        hsv_next.value = dv.value;
        if (dv.neutral)
        begin
            hsv_next.hue = '0;
            hsv_next.sat = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_HSV])
            hsv_reg <= hsv_next;
    end

    // ------------------------------------------------------------------
    // Classification and output register
    // ------------------------------------------------------------------
    out_word_t res_reg, res_next;

    always_comb
    begin
        res_next.color_code     = classify(hsv_reg.hue, hsv_reg.sat, hsv_reg.value);
        res_next.hue_angle      = hsv_reg.hue;
        res_next.saturation_pct = hsv_reg.sat;
        res_next.value_pct      = hsv_reg.value;
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_OUT])
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

/* src/rhcc_checker.sv */
// ----------------------------------------------------------------------------
// rhcc_checker: port-level checks for the colour classifier
// Watches the result channel and the register port of the top level.
// ----------------------------------------------------------------------------
module rhcc_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          res_valid,
    input  logic                          res_ready,
    input  rhcc_pkg::out_word_t           res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rhcc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    input  logic [31:0]                   prdata,
    input  logic                          pready
);
    import rhcc_pkg::*;

    // a stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    // divider outputs stay in range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.hue_angle <= HUE_360 && res.saturation_pct <= 13'd6400)
        else $error("hue or saturation out of range");

    // zero saturation only for neutral pixels, which carry hue 0
    a_neutral: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.saturation_pct == 13'd0 |-> res.hue_angle == 15'd0)
        else $error("neutral pixel with non-zero hue");

    // a black pixel is named black
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.value_pct == 14'd0 |-> res.color_code == CLR_BLACK)
        else $error("zero value not classified black");

    // register read returns what was written
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr[2] == REG_BRIGHTNESS
        ##1 psel && !pwrite && paddr[2] == REG_BRIGHTNESS
        |-> prdata == {24'd0, $past(pwdata[7:0])})
        else $error("brightness offset readback mismatch");

endmodule

bind rgb_hsv_color_classifier rhcc_checker u_rhcc_checker (.*);
